// ===== src/sorted_min_priority_queue_top_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef SORTED_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SMPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SMPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SMPQ_ASSERT_NOW(label, ante, cons)
`define SMPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/smpq_pkg.sv =====
package smpq_pkg;

    localparam int DEPTH = 128;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [KEY_W-1:0] key_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key_out;
        logic [7:0]              held_count;
    } t_out_item;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== src/smpq_cell.sv =====
module smpq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smpq_pkg::t_cell_ctl               i_ctl,
    input  logic signed [smpq_pkg::KEY_W-1:0] i_key,
    input  logic signed [smpq_pkg::KEY_W-1:0] i_prev_key,
    input  logic                              i_prev_valid,
    input  logic                              i_prev_gt,
    input  logic signed [smpq_pkg::KEY_W-1:0] i_next_key,
    input  logic                              i_next_valid,
    output logic signed [smpq_pkg::KEY_W-1:0] o_key,
    output logic                              o_valid,
    output logic                              o_gt
);

    logic signed [smpq_pkg::KEY_W-1:0] r_key;
    logic signed [smpq_pkg::KEY_W-1:0] n_key;
    logic                              r_valid;
    logic                              n_valid;

    // An empty cell counts as holding a key above every other.
    assign o_gt    = !r_valid || (r_key > i_key);
    assign o_key   = r_key;
    assign o_valid = r_valid;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            if (o_gt) begin
                n_key = i_prev_gt ? i_prev_key : i_key;
            end
            n_valid = r_valid || i_prev_valid;
        end else if (i_ctl.rem) begin
            n_key   = i_next_key;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ===== src/sorted_min_priority_queue_top.sv =====
// Sorted minimum priority queue built as a row of key cells.
// The input channel carries an operation code and a signed key: insert,
// remove the minimum, or peek at the minimum. The output channel returns one
// result per operation: a status, the minimum key where one is returned, and
// the number of keys held after the operation.
// Every cell compares its key with the broadcast key in the same cycle, so an
// insert, a remove or a peek acts on all cells at once. The result appears
// on the output in the cycle after the input transfer, and a new operation is
// taken in every cycle while the output is free or being taken, one operation
// per cycle sustained.
// An insert into a full queue is refused with the full status; a remove or a
// peek on an empty queue returns the empty status and a zero key.
// Reset clears the occupancy of every cell and the count; the queue starts
// empty and accepts an operation as soon as reset is released.
// When the receiver stalls, the held result stays on the output and the input
// stops accepting until that result is taken.
`include "sorted_min_priority_queue_top_macros.svh"

module sorted_min_priority_queue_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  smpq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output smpq_pkg::t_out_item o_out_data
);

    localparam int N = smpq_pkg::DEPTH;
    localparam int W = smpq_pkg::CNT_W;

    logic                              in_xfer;
    smpq_pkg::t_cell_ctl               cell_ctl;
    logic signed [smpq_pkg::KEY_W-1:0] w_key [N];
    logic [N-1:0]                      w_valid;
    logic [N-1:0]                      w_gt;

    logic [W-1:0]                      r_count;
    logic [W-1:0]                      n_count;
    logic                              r_out_valid;
    smpq_pkg::t_out_item               r_out_data;
    smpq_pkg::t_out_item               n_out_data;
    logic [W+7:0]                      count_ext;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign count_ext   = {8'd0, n_count};

    always_comb begin
        cell_ctl           = '0;
        n_count            = r_count;
        n_out_data.status  = smpq_pkg::ST_OK;
        n_out_data.key_out = '0;
        case (i_in_data.func)
            smpq_pkg::FUNC_INSERT: begin
                if (r_count == smpq_pkg::CNT_FULL) begin
                    n_out_data.status = smpq_pkg::ST_FULL;
                end else begin
                    cell_ctl.ins = in_xfer;
                    n_count      = r_count + smpq_pkg::CNT_ONE;
                end
            end
            smpq_pkg::FUNC_REMOVE, smpq_pkg::FUNC_PEEK: begin
                if (r_count == smpq_pkg::CNT_ZERO) begin
                    n_out_data.status = smpq_pkg::ST_EMPTY;
                end else begin
                    n_out_data.key_out = w_key[0];
                    if (i_in_data.func == smpq_pkg::FUNC_REMOVE) begin
                        cell_ctl.rem = in_xfer;
                        n_count      = r_count - smpq_pkg::CNT_ONE;
                    end
                end
            end
            default: begin
            end
        endcase
        n_out_data.held_count = count_ext[7:0];
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic signed [smpq_pkg::KEY_W-1:0] prev_key;
        logic                              prev_valid;
        logic                              prev_gt;
        logic signed [smpq_pkg::KEY_W-1:0] next_key;
        logic                              next_valid;

        if (i == 0) begin : g_first
            assign prev_key   = i_in_data.key_in;
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
        end else begin : g_mid
            assign prev_key   = w_key[i-1];
            assign prev_valid = w_valid[i-1];
            assign prev_gt    = w_gt[i-1];
        end

        if (i == N - 1) begin : g_last
            assign next_key   = w_key[i];
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_key   = w_key[i+1];
            assign next_valid = w_valid[i+1];
        end

        smpq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_key        (i_in_data.key_in),
            .i_prev_key   (prev_key),
            .i_prev_valid (prev_valid),
            .i_prev_gt    (prev_gt),
            .i_next_key   (next_key),
            .i_next_valid (next_valid),
            .o_key        (w_key[i]),
            .o_valid      (w_valid[i]),
            .o_gt         (w_gt[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    `SMPQ_ASSERT_NOW(a_head_matches_count, 1'b1, w_valid[0] == (r_count != smpq_pkg::CNT_ZERO))
    `SMPQ_ASSERT_NOW(a_count_bounded, 1'b1, r_count <= smpq_pkg::CNT_FULL)
    `SMPQ_ASSERT_NEXT(a_insert_grows, in_xfer && cell_ctl.ins, r_count == $past(r_count) + smpq_pkg::CNT_ONE)
    `SMPQ_ASSERT_NOW(a_last_valid_full, 1'b1, w_valid[N-1] == (r_count == smpq_pkg::CNT_FULL))

endmodule

// ===== tb/smpq_result_checker.sv =====
`timescale 1ns / 1ps

module smpq_result_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  smpq_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  smpq_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic signed [smpq_pkg::KEY_W-1:0] held_keys[$];
    smpq_pkg::t_out_item               expected_results[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic smpq_pkg::t_out_item apply_queue_op(input smpq_pkg::t_in_item op);
        smpq_pkg::t_out_item res;
        int                  pos;
        res.status = smpq_pkg::ST_OK;
        res.key_out = '0;
        case (op.func)
            smpq_pkg::FUNC_INSERT: begin
                if (held_keys.size() >= smpq_pkg::DEPTH) begin
                    res.status = smpq_pkg::ST_FULL;
                end else begin
                    pos = held_keys.size();
                    while (pos > 0 && held_keys[pos-1] > op.key_in) begin
                        pos--;
                    end
                    held_keys.insert(pos, op.key_in);
                end
            end
            smpq_pkg::FUNC_REMOVE, smpq_pkg::FUNC_PEEK: begin
                if (held_keys.size() == 0) begin
                    res.status = smpq_pkg::ST_EMPTY;
                end else begin
                    res.key_out = held_keys[0];
                    if (op.func == smpq_pkg::FUNC_REMOVE) begin
                        void'(held_keys.pop_front());
                    end
                end
            end
            default: begin
            end
        endcase
        res.held_count = 8'(held_keys.size());
        return res;
    endfunction

    task automatic report_error(input string what);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, what);
        end
    endtask

    // Handshake signals settle by the falling edge and hold until the next
    // rising edge, so sampling here sees exactly what that edge will take.
    always @(negedge i_clk) begin
        smpq_pkg::t_out_item exp_res;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("unexpected result status=%0d key=%0d count=%0d",
                        i_out_data.status, i_out_data.key_out, i_out_data.held_count));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_out_data.status !== exp_res.status) begin
                        report_error($sformatf("status expected %0d, got %0d",
                            exp_res.status, i_out_data.status));
                    end
                    if (i_out_data.key_out !== exp_res.key_out) begin
                        report_error($sformatf("key_out expected %0d, got %0d",
                            exp_res.key_out, i_out_data.key_out));
                    end
                    if (i_out_data.held_count !== exp_res.held_count) begin
                        report_error($sformatf("held_count expected %0d, got %0d",
                            exp_res.held_count, i_out_data.held_count));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_queue_op(i_in_data));
            end
            o_pending = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_sorted_min_priority_queue_top.sv =====
`timescale 1ns / 1ps

module tb_sorted_min_priority_queue_top;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic signed [smpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [smpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    smpq_pkg::t_in_item  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    smpq_pkg::t_out_item out_data;
    int                  fail_count;
    int                  pending;
    int                  burst_left = 0;
    int                  stall_tick = 0;

    always #2 clk = ~clk;

    sorted_min_priority_queue_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    smpq_result_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // The receiver cycles through always ready, coin-flip stalls, rare stalls
    // and a fixed stall pattern, in phases of equal length.
    always @(posedge clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_tick[8:7])
            2'd0: begin
                out_ready <= 1'b1;
            end
            2'd1: begin
                out_ready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                out_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                out_ready <= ((stall_tick % 9) < 3);
            end
        endcase
    end

    function automatic logic signed [smpq_pkg::KEY_W-1:0] pick_key();
        logic signed [smpq_pkg::KEY_W-1:0] k;
        case ($urandom_range(0, 2))
            0: begin
                k = $urandom;
            end
            1: begin
                k = 32'($urandom_range(0, 15)) - 32'd8;
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: k = KEY_MIN;
                    1: k = KEY_MAX;
                    2: k = KEY_MIN + 1;
                    3: k = KEY_MAX - 1;
                    4: k = -1;
                    default: k = 0;
                endcase
            end
        endcase
        return k;
    endfunction

    // Called at a rising edge; returns at the rising edge of the transfer, or later when an idle gap follows it.
    task automatic issue(input logic [1:0] f, input logic signed [smpq_pkg::KEY_W-1:0] k);
        logic rdy;
        int   gap;
        in_valid <= 1'b1;
        in_data <= '{func: f, key_in: k};
        do begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end while (!rdy);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [1:0] f;
        int         r;
        int         ins_pct;
        int         seg_len;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        issue(smpq_pkg::FUNC_PEEK, 0);
        issue(smpq_pkg::FUNC_REMOVE, KEY_MAX);
        issue(FUNC_NONE, KEY_MIN);
        issue(smpq_pkg::FUNC_INSERT, KEY_MAX);
        issue(smpq_pkg::FUNC_INSERT, KEY_MIN);
        issue(smpq_pkg::FUNC_INSERT, 0);
        issue(smpq_pkg::FUNC_INSERT, -1);
        issue(smpq_pkg::FUNC_INSERT, 0);
        issue(smpq_pkg::FUNC_INSERT, 1);
        issue(smpq_pkg::FUNC_INSERT, KEY_MIN);
        issue(smpq_pkg::FUNC_PEEK, -1);
        issue(FUNC_NONE, 32'sh5A5A_A5A5);
        issue(smpq_pkg::FUNC_REMOVE, 0);
        issue(smpq_pkg::FUNC_REMOVE, 0);
        issue(smpq_pkg::FUNC_PEEK, 0);
        issue(smpq_pkg::FUNC_REMOVE, 0);
        issue(smpq_pkg::FUNC_INSERT, KEY_MAX);
        issue(smpq_pkg::FUNC_REMOVE, 0);
        issue(smpq_pkg::FUNC_REMOVE, 0);
        issue(smpq_pkg::FUNC_REMOVE, 0);
        issue(smpq_pkg::FUNC_REMOVE, 0);
        issue(smpq_pkg::FUNC_REMOVE, 0);
        issue(smpq_pkg::FUNC_PEEK, 0);
        issue(smpq_pkg::FUNC_INSERT, KEY_MAX - 1);

        // Alternate fill and drain phases so that both the full and the
        // empty queue are reached repeatedly.
        for (int seg = 0; seg < 4; seg++) begin
            ins_pct = (seg % 2 == 0) ? 88 : 5;
            seg_len = (seg % 2 == 0) ? 180 : 200;
            for (int n = 0; n < seg_len; n++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct) begin
                    f = smpq_pkg::FUNC_INSERT;
                end else begin
                    r = $urandom_range(0, 19);
                    f = (r < 15) ? smpq_pkg::FUNC_REMOVE :
                        (r < 19) ? smpq_pkg::FUNC_PEEK : FUNC_NONE;
                end
                issue(f, pick_key());
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
